>>> hw/rtl/hidrd_pkg.sv
// Package for the HID report descriptor size parser.
// Holds item codes, status codes, the table entry type and sizing helpers.
// No dependencies.
package hidrd_pkg;

    // Default depth of the report id table.
    localparam int MAX_REPORT_IDS_DEF = 16;

    // Field widths.
    localparam int ACTION_W = 2;
    localparam int BYTE_W = 8;
    localparam int ID_W = 8;
    localparam int KIND_W = 2;
    localparam int STATUS_W = 2;
    localparam int SIZE_W = 14;
    localparam int COUNT_W = 5;
    localparam int BITS_W = 16;

    // Actions carried by an input transfer.
    localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SIZE_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MAX_QUERY = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_PUSH_POP = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    // Report kinds.
    localparam logic [KIND_W-1:0] KIND_INPUT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OUTPUT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FEATURE = 2'd2;

    // Item types and tags of short items.
    localparam logic [1:0] TYPE_MAIN = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
    localparam logic [3:0] TAG_INPUT = 4'd8;
    localparam logic [3:0] TAG_OUTPUT = 4'd9;
    localparam logic [3:0] TAG_FEATURE = 4'd11;
    localparam logic [3:0] TAG_REPORT_SIZE = 4'd7;
    localparam logic [3:0] TAG_REPORT_ID = 4'd8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
    localparam logic [3:0] TAG_PUSH = 4'd10;
    localparam logic [3:0] TAG_POP = 4'd11;

    // Boot mouse answers.
    localparam logic [SIZE_W-1:0] BOOT_MOUSE_BYTES = 14'd3;
    localparam logic [COUNT_W-1:0] BOOT_MOUSE_COUNT = 5'd1;

    // One row of the report id table.
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [BITS_W-1:0] in_bits;
        logic [BITS_W-1:0] out_bits;
        logic [BITS_W-1:0] feat_bits;
    } entry_t;

    // What the table scan is doing.
    typedef enum logic [1:0] {
        OP_MAIN,
        OP_QUERY,
        OP_MAX
    } scan_op_t;

    // Bit count rounded up to whole bytes.
    function automatic logic [SIZE_W-1:0] bytes_of(input logic [BITS_W-1:0] bits);
        logic [BITS_W:0] sum;
        sum = {1'b0, bits} + (BITS_W + 1)'(7);
        return sum[BITS_W:3];
    endfunction

endpackage

>>> hw/rtl/hid_report_descriptor_size_parser_top.sv
// Top level of the HID report descriptor size parser.
// Each accepted input passes the finish step (ST_FIN), which waits while the
// output stalls, into the result register. Main items and, outside pointer
// mode, size and max queries first read table rows in turn (ST_READ, ST_CMP),
// at most MAX_REPORT_IDS rows. One item at a time: input stalls until idle.
// Reset (rst_n, async) empties the table through its fill count; no clear pass.
module hid_report_descriptor_size_parser_top
    import hidrd_pkg::*;
#(
    parameter int MAX_REPORT_IDS = MAX_REPORT_IDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                pointer_mode,
    // Input channel.
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [BYTE_W-1:0]   desc_byte,
    input  logic                last,
    input  logic [ID_W-1:0]     query_id,
    input  logic [KIND_W-1:0]   query_kind,
    // Output channel.
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SIZE_W-1:0]   size_bytes,
    output logic [COUNT_W-1:0]  report_count
);

    localparam int CNT_W = $clog2(MAX_REPORT_IDS + 1);
    localparam int IDX_W = (MAX_REPORT_IDS > 1) ? $clog2(MAX_REPORT_IDS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    scan_op_t op_reg, op_next;

    logic pointer_mode_reg;
    logic [CNT_W-1:0] entries_used_reg, entries_used_next;
    logic [BYTE_W-1:0] item_header_reg, item_header_next;
    logic [2:0] data_bytes_left_reg, data_bytes_left_next;
    logic [BITS_W-1:0] item_data_reg, item_data_next;
    logic [BITS_W-1:0] global_size_reg, global_size_next;
    logic [BITS_W-1:0] global_count_reg, global_count_next;
    logic [ID_W-1:0] global_id_reg, global_id_next;
    logic [STATUS_W-1:0] parse_error_reg, parse_error_next;
    logic parse_done_reg, parse_done_next;

    logic [ID_W-1:0] key_reg, key_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BITS_W-1:0] inc_reg, inc_next;
    logic [BITS_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;

    logic out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SIZE_W-1:0] size_bytes_reg, size_bytes_next;
    logic [COUNT_W-1:0] report_count_reg, report_count_next;

    // Table memory with one write and one registered read port.
    entry_t table_mem [MAX_REPORT_IDS];
    entry_t rd_data_reg;
    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t mem_wdata;

    logic in_fire;
    logic out_free;
    logic [BITS_W-1:0] product;

    // Byte parser decode.
    logic [1:0] size_code;
    logic [2:0] n_bytes;
    logic [2:0] total_bytes;
    logic [2:0] pos;
    logic [BITS_W-1:0] data_merged;
    logic run;
    logic [BYTE_W-1:0] run_hdr;
    logic [BITS_W-1:0] run_data;
    logic [1:0] run_type;
    logic [3:0] run_tag;
    logic [BITS_W-1:0] field_bits;
    logic [SIZE_W-1:0] field_bytes;

    assign in_fire = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    // The mode changes only while no input transfer is offered or in progress.
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign product = global_size_reg * global_count_reg;

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign size_bytes = size_bytes_reg;
    assign report_count = report_count_reg;

    // Size code and data position of the byte being parsed.
    always_comb
    begin
        size_code = desc_byte[1:0];
        n_bytes = (size_code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, size_code};
        total_bytes = (item_header_reg[1:0] == SIZE_CODE_FOUR) ? 3'd4
                                                                : {1'b0, item_header_reg[1:0]};
        pos = total_bytes - data_bytes_left_reg;
        data_merged = item_data_reg;
        if (pos == 3'd0)
        begin
            data_merged[7:0] = desc_byte;
        end
        else if (pos == 3'd1)
        begin
            data_merged[15:8] = desc_byte;
        end
    end

    // Field of the row just read that matches the pending kind.
    always_comb
    begin
        unique case (kind_reg)
            KIND_INPUT:   field_bits = rd_data_reg.in_bits;
            KIND_OUTPUT:  field_bits = rd_data_reg.out_bits;
            KIND_FEATURE: field_bits = rd_data_reg.feat_bits;
            default:      field_bits = '0;
        endcase
        field_bytes = bytes_of(field_bits);
    end

    // Sequencer and parser next state.
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        entries_used_next = entries_used_reg;
        item_header_next = item_header_reg;
        data_bytes_left_next = data_bytes_left_reg;
        item_data_next = item_data_reg;
        global_size_next = global_size_reg;
        global_count_next = global_count_reg;
        global_id_next = global_id_reg;
        parse_error_next = parse_error_reg;
        parse_done_next = parse_done_reg;
        key_next = key_reg;
        kind_next = kind_reg;
        inc_next = inc_reg;
        best_next = best_reg;
        idx_next = idx_reg;
        res_status_next = res_status_reg;
        res_size_next = res_size_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next = status_reg;
        size_bytes_next = size_bytes_reg;
        report_count_next = report_count_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg[IDX_W-1:0];
        mem_wdata = rd_data_reg;
        run = 1'b0;
        run_hdr = desc_byte;
        run_data = '0;
        run_type = run_hdr[3:2];
        run_tag = run_hdr[7:4];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_FIN;
                    res_size_next = '0;
                    idx_next = '0;
                    best_next = '0;
                    unique case (action)
                        ACT_BYTE:
                        begin
                            if (!parse_done_reg && parse_error_reg == STAT_OK)
                            begin
                                parse_done_next = last;
                                if (data_bytes_left_reg == 3'd0)
                                begin
                                    // Prefix byte.
                                    item_header_next = desc_byte;
                                    item_data_next = '0;
                                    if (n_bytes == 3'd0)
                                    begin
                                        run = 1'b1;
                                    end
                                    else if (!last)
                                    begin
                                        data_bytes_left_next = n_bytes;
                                    end
                                end
                                else
                                begin
                                    // Data byte, little-endian.
                                    item_data_next = data_merged;
                                    if (data_bytes_left_reg == 3'd1)
                                    begin
                                        data_bytes_left_next = 3'd0;
                                        run = 1'b1;
                                        run_hdr = item_header_reg;
                                        run_data = data_merged;
                                    end
                                    else
                                    begin
                                        data_bytes_left_next = last ? 3'd0
                                                                    : data_bytes_left_reg - 3'd1;
                                    end
                                end
                            end
                            // Execute a completed item.
                            run_type = run_hdr[3:2];
                            run_tag = run_hdr[7:4];
                            if (run && run_type == TYPE_MAIN &&
                                (run_tag == TAG_INPUT || run_tag == TAG_OUTPUT ||
                                 run_tag == TAG_FEATURE))
                            begin
                                state_next = ST_READ;
                                op_next = OP_MAIN;
                                key_next = global_id_reg;
                                inc_next = product;
                                if (run_tag == TAG_INPUT)
                                begin
                                    kind_next = KIND_INPUT;
                                end
                                else if (run_tag == TAG_OUTPUT)
                                begin
                                    kind_next = KIND_OUTPUT;
                                end
                                else
                                begin
                                    kind_next = KIND_FEATURE;
                                end
                            end
                            else if (run && run_type == TYPE_GLOBAL)
                            begin
                                if (run_tag == TAG_REPORT_SIZE)
                                begin
                                    global_size_next = run_data;
                                end
                                else if (run_tag == TAG_REPORT_ID)
                                begin
                                    global_id_next = run_data[ID_W-1:0];
                                end
                                else if (run_tag == TAG_REPORT_COUNT)
                                begin
                                    global_count_next = run_data;
                                end
                                else if (run_tag == TAG_PUSH || run_tag == TAG_POP)
                                begin
                                    parse_error_next = STAT_PUSH_POP;
                                end
                            end
                            res_status_next = parse_error_next;
                        end
                        ACT_SIZE_QUERY:
                        begin
                            res_status_next = STAT_OK;
                            if (pointer_mode_reg)
                            begin
                                res_size_next = BOOT_MOUSE_BYTES;
                            end
                            else
                            begin
                                state_next = ST_READ;
                                op_next = OP_QUERY;
                                key_next = query_id;
                                kind_next = query_kind;
                            end
                        end
                        ACT_MAX_QUERY:
                        begin
                            res_status_next = STAT_OK;
                            if (pointer_mode_reg)
                            begin
                                res_size_next = BOOT_MOUSE_BYTES;
                            end
                            else
                            begin
                                state_next = ST_READ;
                                op_next = OP_MAX;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            res_status_next = STAT_OK;
                            entries_used_next = '0;
                            item_header_next = '0;
                            data_bytes_left_next = '0;
                            item_data_next = '0;
                            global_size_next = '0;
                            global_count_next = '0;
                            global_id_next = '0;
                            parse_error_next = STAT_OK;
                            parse_done_next = 1'b0;
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                if (idx_reg < entries_used_reg)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    // Scan ran past the used rows.
                    state_next = ST_FIN;
                    unique case (op_reg)
                        OP_MAIN:
                        begin
                            if (entries_used_reg < CNT_W'(MAX_REPORT_IDS))
                            begin
                                mem_we = 1'b1;
                                mem_waddr = entries_used_reg[IDX_W-1:0];
                                mem_wdata.id = key_reg;
                                mem_wdata.in_bits = (kind_reg == KIND_INPUT) ? inc_reg : '0;
                                mem_wdata.out_bits = (kind_reg == KIND_OUTPUT) ? inc_reg : '0;
                                mem_wdata.feat_bits = (kind_reg == KIND_FEATURE) ? inc_reg : '0;
                                entries_used_next = entries_used_reg + CNT_W'(1);
                                res_status_next = parse_error_reg;
                            end
                            else
                            begin
                                parse_error_next = STAT_TABLE_FULL;
                                res_status_next = STAT_TABLE_FULL;
                            end
                        end
                        OP_QUERY:
                        begin
                            res_status_next = STAT_NOT_FOUND;
                            res_size_next = '0;
                        end
                        OP_MAX:
                        begin
                            res_status_next = STAT_OK;
                            res_size_next = bytes_of(best_reg);
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_CMP:
            begin
                state_next = ST_READ;
                idx_next = idx_reg + CNT_W'(1);
                unique case (op_reg)
                    OP_MAIN:
                    begin
                        if (rd_data_reg.id == key_reg)
                        begin
                            // Accumulate into the matching row, wrapping at 16 bits.
                            mem_we = 1'b1;
                            if (kind_reg == KIND_INPUT)
                            begin
                                mem_wdata.in_bits = rd_data_reg.in_bits + inc_reg;
                            end
                            else if (kind_reg == KIND_OUTPUT)
                            begin
                                mem_wdata.out_bits = rd_data_reg.out_bits + inc_reg;
                            end
                            else
                            begin
                                mem_wdata.feat_bits = rd_data_reg.feat_bits + inc_reg;
                            end
                            res_status_next = parse_error_reg;
                            state_next = ST_FIN;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (rd_data_reg.id == key_reg)
                        begin
                            state_next = ST_FIN;
                            res_size_next = field_bytes;
                            res_status_next = (field_bytes == '0) ? STAT_NOT_FOUND : STAT_OK;
                        end
                    end
                    OP_MAX:
                    begin
                        if (rd_data_reg.in_bits > best_reg)
                        begin
                            best_next = rd_data_reg.in_bits;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_FIN:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    out_valid_next = 1'b1;
                    status_next = res_status_reg;
                    size_bytes_next = res_size_reg;
                    report_count_next = pointer_mode_reg ? BOOT_MOUSE_COUNT
                                                         : COUNT_W'(entries_used_reg);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_MAIN;
            pointer_mode_reg <= 1'b0;
            entries_used_reg <= '0;
            item_header_reg <= '0;
            data_bytes_left_reg <= '0;
            item_data_reg <= '0;
            global_size_reg <= '0;
            global_count_reg <= '0;
            global_id_reg <= '0;
            parse_error_reg <= STAT_OK;
            parse_done_reg <= 1'b0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            if (cfg_valid && cfg_ready)
            begin
                pointer_mode_reg <= pointer_mode;
            end
            entries_used_reg <= entries_used_next;
            item_header_reg <= item_header_next;
            data_bytes_left_reg <= data_bytes_left_next;
            item_data_reg <= item_data_next;
            global_size_reg <= global_size_next;
            global_count_reg <= global_count_next;
            global_id_reg <= global_id_next;
            parse_error_reg <= parse_error_next;
            parse_done_reg <= parse_done_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        kind_reg <= kind_next;
        inc_reg <= inc_next;
        best_reg <= best_next;
        res_status_reg <= res_status_next;
        res_size_reg <= res_size_next;
        status_reg <= status_next;
        size_bytes_reg <= size_bytes_next;
        report_count_reg <= report_count_next;
    end

    // Table memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= table_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // A compared row always lies inside the used part of the table.
    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (idx_reg < entries_used_reg))
        else $error("table compare beyond used rows");

    // The fill count never passes the table depth.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_used_reg <= CNT_W'(MAX_REPORT_IDS))
        else $error("table fill count out of range");

    // Pending data byte count is 0, 1, 2 or 4 minus bytes already taken.
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        data_bytes_left_reg <= 3'd4)
        else $error("data byte count out of range");

    // A new result appears only out of the finish step.
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result produced outside finish step");

    // The fill count moves only while scanning or on an accepted clear.
    a_used_change: assert property (@(posedge clk) disable iff (!rst_n)
        (entries_used_reg != $past(entries_used_reg)) |->
            ($past(state_reg == ST_READ) || $past(in_fire && action == ACT_CLEAR)))
        else $error("fill count changed unexpectedly");

endmodule
